[sv/evm_lm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// evm_lm_pkg
// shared types and constants of the linear memory unit
// ----------------------------------------------------------------------------
package evm_lm_pkg;

    localparam int MEM_BYTES  = 65536;
    localparam int WORD_BYTES = 32;
    localparam int ADDR_W     = $clog2(MEM_BYTES);
    localparam int SIZE_W     = 17;

    localparam logic [2:0] OP_READ_BYTE  = 3'd0;
    localparam logic [2:0] OP_WRITE_BYTE = 3'd1;
    localparam logic [2:0] OP_READ_WORD  = 3'd2;
    localparam logic [2:0] OP_WRITE_WORD = 3'd3;
    localparam logic [2:0] OP_COPY       = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    typedef struct packed {
        logic [2:0]        operation;
        logic [63:0]       offset;
        logic [63:0]       source_offset;
        logic [SIZE_W-1:0] copy_length;
        logic [7:0]        write_byte;
        logic [63:0]       word_in_3;
        logic [63:0]       word_in_2;
        logic [63:0]       word_in_1;
        logic [63:0]       word_in_0;
    } in_item_t;

    typedef struct packed {
        logic              ok;
        logic [7:0]        read_byte;
        logic [63:0]       word_out_3;
        logic [63:0]       word_out_2;
        logic [63:0]       word_out_1;
        logic [63:0]       word_out_0;
        logic [SIZE_W-1:0] active_bytes;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage
`default_nettype wire

[sv/evm_linear_memory_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// evm_linear_memory_unit
// byte-addressed machine memory with an active size grown in 32-byte steps
// ----------------------------------------------------------------------------
// usage:
//   s_item carries one request (read/write byte, read/write word, copy, clear),
//   taken on s_valid && s_ready; every request gives one m_item with ok,
//   the data read and the active size after the request
//   one request is worked at a time, through one byte-wide ram port
//   reads, writes and copies move one byte at a time through that port; a copy
//   reads each byte and then writes it; failed or zero-length requests go straight
//   to the result, and a clear writes zero to every byte of the ram
//   after reset the ram is zeroed by a pass over every byte with s_ready low
//   the result waits in an output register; while m_ready is low the finished
//   item is held and the next result waits until it is taken
// ----------------------------------------------------------------------------
module evm_linear_memory_unit (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  evm_lm_pkg::in_item_t    s_item,
    output logic                    m_valid,
    input  wire                     m_ready,
    output evm_lm_pkg::out_item_t   m_item
);
    import evm_lm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BASE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_RADDR = 4'd3;
    localparam logic [3:0] S_RDATA = 4'd4;
    localparam logic [3:0] S_WRITE = 4'd5;
    localparam logic [3:0] S_CPRD  = 4'd6;
    localparam logic [3:0] S_CPWR  = 4'd7;
    localparam logic [3:0] S_CLEAR = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]        state_reg, state_next;
    in_item_t          item_reg;
    logic [63:0]       base_reg;
    logic              back_reg;        // copy runs from the top down
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0] active_reg, active_next;
    logic              ok_reg, ok_next;
    logic              reply_reg;       // clear pass answers with an item
    logic [255:0]      acc_reg, acc_next;
    logic              m_valid_reg;
    out_item_t         m_item_reg;
    ram_req_t          ram_req;
    logic [7:0]        ram_rdata;

    // bound check
    logic [SIZE_W-1:0] len_sel;
    logic [64:0]       end_sum;
    logic [65:0]       up_sum;
    logic [65:0]       up_round;
    logic              fits;

    always_comb begin
        unique case (item_reg.operation)
            OP_READ_WORD, OP_WRITE_WORD: len_sel = SIZE_W'(WORD_BYTES);
            OP_COPY:                     len_sel = item_reg.copy_length;
            default:                     len_sel = SIZE_W'(1);
        endcase
        end_sum  = {1'b0, base_reg} + {48'd0, len_sel};
        up_sum   = {1'b0, end_sum} + 66'(WORD_BYTES - 1);
        up_round = up_sum & ~66'(WORD_BYTES - 1);
        fits     = !end_sum[64] && (end_sum <= 65'(MEM_BYTES))
                   && (up_round <= 66'(MEM_BYTES));
    end

    evm_lm_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ram port
    always_comb begin
        ram_req.we    = 1'b0;
        ram_req.waddr = item_reg.offset[ADDR_W-1:0] + idx_reg;
        ram_req.wdata = acc_reg[255:248];
        ram_req.raddr = item_reg.offset[ADDR_W-1:0] + idx_reg;
        unique case (state_reg)
            S_WRITE: ram_req.we = 1'b1;
            S_CPRD:  ram_req.raddr = item_reg.source_offset[ADDR_W-1:0] + idx_reg;
            S_CPWR: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = ram_rdata;
            end
            S_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                ram_req.wdata = 8'd0;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        ok_next     = ok_reg;
        acc_next    = acc_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                state_next = S_BASE;
                ok_next    = 1'b0;
                idx_next   = '0;
            end
            S_BASE: state_next = S_CHECK;
            S_CHECK: begin
                state_next = S_DONE;
                acc_next   = '0;
                cnt_next   = len_sel;
                idx_next   = back_reg ? ADDR_W'(item_reg.copy_length - SIZE_W'(1))
                                      : '0;
                if (item_reg.operation == OP_CLEAR) begin
                    state_next = S_CLEAR;
                end else if (item_reg.operation == OP_COPY &&
                             item_reg.copy_length == '0) begin
                    ok_next = 1'b1;
                end else if (item_reg.operation <= OP_COPY && fits) begin
                    ok_next = 1'b1;
                    if (up_round[SIZE_W-1:0] > active_reg) begin
                        active_next = up_round[SIZE_W-1:0];
                    end
                    unique case (item_reg.operation)
                        OP_READ_BYTE, OP_READ_WORD: state_next = S_RADDR;
                        OP_WRITE_BYTE: begin
                            state_next = S_WRITE;
                            acc_next   = {item_reg.write_byte, 248'd0};
                        end
                        OP_WRITE_WORD: begin
                            state_next = S_WRITE;
                            acc_next   = {item_reg.word_in_3, item_reg.word_in_2,
                                          item_reg.word_in_1, item_reg.word_in_0};
                        end
                        default: state_next = S_CPRD;
                    endcase
                end
            end
            S_RADDR: state_next = S_RDATA;
            S_RDATA: begin
                acc_next = {acc_reg[247:0], ram_rdata};
                idx_next = idx_reg + ADDR_W'(1);
                cnt_next = cnt_reg - SIZE_W'(1);
                state_next = (cnt_reg == SIZE_W'(1)) ? S_DONE : S_RADDR;
            end
            S_WRITE: begin
                acc_next = {acc_reg[247:0], 8'd0};
                idx_next = idx_reg + ADDR_W'(1);
                cnt_next = cnt_reg - SIZE_W'(1);
                if (cnt_reg == SIZE_W'(1)) state_next = S_DONE;
            end
            S_CPRD: state_next = S_CPWR;
            S_CPWR: begin
                idx_next = back_reg ? idx_reg - ADDR_W'(1) : idx_reg + ADDR_W'(1);
                cnt_next = cnt_reg - SIZE_W'(1);
                state_next = (cnt_reg == SIZE_W'(1)) ? S_DONE : S_CPRD;
            end
            S_CLEAR: begin
                idx_next    = idx_reg + ADDR_W'(1);
                active_next = '0;
                ok_next     = 1'b1;
                acc_next    = '0;
                if (idx_reg == '1) state_next = reply_reg ? S_DONE : S_IDLE;
            end
            S_DONE: if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            active_reg  <= '0;
            ok_reg      <= 1'b0;
            reply_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            ok_reg     <= ok_next;
            if (state_reg == S_IDLE && s_valid) reply_reg <= 1'b1;
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (state_reg == S_IDLE && s_valid) item_reg <= s_item;
        if (state_reg == S_BASE) begin
            base_reg <= item_reg.offset;
            back_reg <= 1'b0;
            if (item_reg.operation == OP_COPY) begin
                if (item_reg.source_offset > item_reg.offset) begin
                    base_reg <= item_reg.source_offset;
                end else if (item_reg.offset > item_reg.source_offset) begin
                    back_reg <= 1'b1;
                end
            end
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_item_reg.ok           <= ok_reg;
            m_item_reg.active_bytes <= active_reg;
            m_item_reg.read_byte    <= (ok_reg && item_reg.operation == OP_READ_BYTE)
                                       ? acc_reg[7:0] : 8'd0;
            if (ok_reg && item_reg.operation == OP_READ_WORD) begin
                {m_item_reg.word_out_3, m_item_reg.word_out_2,
                 m_item_reg.word_out_1, m_item_reg.word_out_0} <= acc_reg;
            end else begin
                {m_item_reg.word_out_3, m_item_reg.word_out_2,
                 m_item_reg.word_out_1, m_item_reg.word_out_0} <= '0;
            end
        end
    end

endmodule
`default_nettype wire

[sv/evm_lm_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// evm_lm_ram
// byte-wide store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module evm_lm_ram (
    input  wire                    aclk,
    input  evm_lm_pkg::ram_req_t   req,
    output logic [7:0]             rdata
);
    import evm_lm_pkg::*;

    logic [7:0] mem [MEM_BYTES];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule
`default_nettype wire
